@@ design/wfd_pkg.sv @@
// Shared types and codes for the weighted fair task dispatcher.
// No dependencies; used by every module of the dispatcher.
package wfd_pkg;

  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int WGT_W   = 6;
  localparam int VR_W    = 22;
  localparam int NOW_W   = 20;
  localparam int BS_W    = 8;
  localparam int RUN_W   = BS_W;
  localparam int PROD_W  = RUN_W + WGT_W;
  // widest slot index over the supported slot counts (up to 32)
  localparam int MAX_IDX_W = 5;

  localparam logic [VR_W-1:0]  VR_MAX  = {VR_W{1'b1}};
  localparam logic [NOW_W-1:0] NOW_MAX = {NOW_W{1'b1}};

  localparam logic [1:0] FUNC_LOAD     = 2'd0;
  localparam logic [1:0] FUNC_DISPATCH = 2'd1;
  localparam logic [1:0] FUNC_CLEAR    = 2'd2;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_RAN  = 2'd1;
  localparam logic [1:0] KIND_IDLE = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [BS_W-1:0] SLICE_LIMIT_RST = 8'd2;

  // outcome of the slot search
  typedef struct packed {
    logic                 found;
    logic [MAX_IDX_W-1:0] idx;
    logic                 pending;
    logic [ARR_W-1:0]     next_arr;
  } pick_t;

endpackage

@@ design/weighted_fair_task_dispatcher.sv @@
// Top level of the weighted fair task dispatcher: input register, slot
// state, execute logic and result register. Uses wfd_pkg, wfd_cfg, wfd_pick.
//
//  port group   | direction | handshake           | contents
//  in_*         | in        | in_valid / in_stall | func, slot, arrival, burst, priority
//  out_*        | out       | out_valid/out_stall | kind, slot, length, times
//  psel..prdata | in/out    | APB setup + access  | slice limit at byte address 0
//
// One item per cycle sustained while the output is not stalled. An item goes from the
// input register through the single-pass execute into the result register. Each item's
// state update lands as it leaves the input register, so the next item sees it. Reset
// (rst_n low, synchronous) clears all slots and time and sets the slice limit to 2.
// out_stall holds the result register and, once the input register is full, in_stall.
module weighted_fair_task_dispatcher #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_task_slot,
  input  logic [15:0] in_arrival,
  input  logic [15:0] in_burst,
  input  logic [5:0]  in_priority_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_ran_slot,
  output logic [15:0] out_length,
  output logic [19:0] out_end_time,
  output logic        out_finished,
  output logic [19:0] out_turnaround,
  output logic [19:0] out_waiting,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ARR_W = wfd_pkg::ARR_W;
  localparam int NOW_W = wfd_pkg::NOW_W;
  localparam int VR_W  = wfd_pkg::VR_W;
  localparam int RUN_W = wfd_pkg::RUN_W;

  // configuration
  logic [wfd_pkg::BS_W-1:0] slice_limit;

  wfd_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .slice_limit(slice_limit)
  );

  // input register
  logic        s1_valid_r;
  logic [1:0]  s1_func_r;
  logic [2:0]  s1_slot_r;
  logic [15:0] s1_arrival_r;
  logic [15:0] s1_burst_r;
  logic [5:0]  s1_prio_r;
  logic        exec_fire;
  logic        in_xfer;

  assign exec_fire = s1_valid_r && !(out_valid && out_stall);
  assign in_stall  = s1_valid_r && !exec_fire;
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (exec_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_func_r    <= in_func;
      s1_slot_r    <= in_task_slot;
      s1_arrival_r <= in_arrival;
      s1_burst_r   <= in_burst;
      s1_prio_r    <= in_priority_req;
    end
  end

  // slot state
  logic [SLOTS-1:0]                         slot_valid_r;
  logic [SLOTS-1:0][ARR_W-1:0]              slot_arrival_r;
  logic [SLOTS-1:0][wfd_pkg::BURST_W-1:0]   slot_burst_r;
  logic [SLOTS-1:0][wfd_pkg::BURST_W-1:0]   slot_rem_r;
  logic [SLOTS-1:0][wfd_pkg::WGT_W-1:0]     slot_weight_r;
  logic [SLOTS-1:0][VR_W-1:0]               slot_vr_r;
  logic [NOW_W-1:0]                         now_r;
  logic [SLOTS-1:0]                         elig;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      elig[i] = slot_valid_r[i] && (slot_rem_r[i] != '0);
    end
  end

  wfd_pkg::pick_t pick;

  wfd_pick #(.SLOTS(SLOTS)) u_pick (
    .elig(elig),
    .vr  (slot_vr_r),
    .arr (slot_arrival_r),
    .now (now_r),
    .pick(pick)
  );

  // execute
  logic [IW-1:0]                   sel;
  logic [IW-1:0]                   ld_idx;
  logic                            ld_ok;
  logic [wfd_pkg::BS_W-1:0]        bs;
  logic [wfd_pkg::BURST_W-1:0]     rem_sel;
  logic [RUN_W-1:0]                run;
  logic [wfd_pkg::WGT_W-1:0]       wgt;
  logic [wfd_pkg::PROD_W-1:0]      prod;
  logic [VR_W:0]                   vr_sum;
  logic [VR_W-1:0]                 vr_new;
  logic [NOW_W:0]                  now_sum;
  logic [NOW_W-1:0]                now_run;
  logic [wfd_pkg::BURST_W-1:0]     rem_new;
  logic [NOW_W-1:0]                turn;
  logic [NOW_W-1:0]                burst_ext;
  logic [NOW_W-1:0]                wait_t;

  assign sel     = IW'(pick.idx);
  assign ld_idx  = IW'(s1_slot_r);
  assign ld_ok   = (32'(s1_slot_r) < SLOTS);
  assign bs      = (slice_limit == '0) ? wfd_pkg::BS_W'(1) : slice_limit;
  assign rem_sel = slot_rem_r[sel];
  assign run     = (rem_sel < {{(wfd_pkg::BURST_W - RUN_W){1'b0}}, bs})
                   ? rem_sel[RUN_W-1:0] : bs;
  assign wgt     = (slot_weight_r[sel] == '0) ? wfd_pkg::WGT_W'(1) : slot_weight_r[sel];
  assign prod    = {{wfd_pkg::WGT_W{1'b0}}, run} * {{RUN_W{1'b0}}, wgt};
  assign vr_sum  = {1'b0, slot_vr_r[sel]} + {{(VR_W + 1 - wfd_pkg::PROD_W){1'b0}}, prod};
  assign vr_new  = vr_sum[VR_W] ? wfd_pkg::VR_MAX : vr_sum[VR_W-1:0];
  assign now_sum = {1'b0, now_r} + {{(NOW_W + 1 - RUN_W){1'b0}}, run};
  assign now_run = now_sum[NOW_W] ? wfd_pkg::NOW_MAX : now_sum[NOW_W-1:0];
  assign rem_new = rem_sel - {{(wfd_pkg::BURST_W - RUN_W){1'b0}}, run};
  assign turn    = now_run - {{(NOW_W - ARR_W){1'b0}}, slot_arrival_r[sel]};
  assign burst_ext = {{(NOW_W - wfd_pkg::BURST_W){1'b0}}, slot_burst_r[sel]};
  // clamp at zero: only reachable once time has saturated
  assign wait_t  = (turn >= burst_ext) ? (turn - burst_ext) : '0;

  logic [1:0]       kind_nxt;
  logic [2:0]       slot_nxt;
  logic [15:0]      len_nxt;
  logic             fin_nxt;
  logic [NOW_W-1:0] turn_nxt;
  logic [NOW_W-1:0] wait_nxt;
  logic [NOW_W-1:0] now_nxt;
  logic             do_load;
  logic             do_run;
  logic             do_clear;

  always_comb begin
    kind_nxt = wfd_pkg::KIND_NONE;
    slot_nxt = '0;
    len_nxt  = '0;
    fin_nxt  = 1'b0;
    turn_nxt = '0;
    wait_nxt = '0;
    now_nxt  = now_r;
    do_load  = 1'b0;
    do_run   = 1'b0;
    do_clear = 1'b0;
    unique case (s1_func_r)
      wfd_pkg::FUNC_LOAD: begin
        kind_nxt = wfd_pkg::KIND_ACK;
        slot_nxt = s1_slot_r;
        do_load  = ld_ok;
      end
      wfd_pkg::FUNC_CLEAR: begin
        kind_nxt = wfd_pkg::KIND_ACK;
        now_nxt  = '0;
        do_clear = 1'b1;
      end
      wfd_pkg::FUNC_DISPATCH: begin
        if (pick.found) begin
          kind_nxt = wfd_pkg::KIND_RAN;
          slot_nxt = 3'(pick.idx);
          len_nxt  = 16'(run);
          now_nxt  = now_run;
          do_run   = 1'b1;
          if (rem_new == '0) begin
            fin_nxt  = 1'b1;
            turn_nxt = turn;
            wait_nxt = wait_t;
          end
        end else if (pick.pending) begin
          // idle up to the next arrival, which lies ahead of now
          kind_nxt = wfd_pkg::KIND_IDLE;
          len_nxt  = pick.next_arr - now_r[ARR_W-1:0];
          now_nxt  = {{(NOW_W - ARR_W){1'b0}}, pick.next_arr};
        end
      end
      default: begin
        kind_nxt = wfd_pkg::KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      now_r        <= '0;
    end else if (exec_fire) begin
      now_r <= now_nxt;
      if (do_clear) begin
        slot_valid_r <= '0;
      end else if (do_load) begin
        slot_valid_r[ld_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && do_load) begin
      slot_arrival_r[ld_idx] <= s1_arrival_r;
      slot_burst_r[ld_idx]   <= s1_burst_r;
      slot_rem_r[ld_idx]     <= s1_burst_r;
      slot_weight_r[ld_idx]  <= s1_prio_r;
      slot_vr_r[ld_idx]      <= '0;
    end else if (exec_fire && do_run) begin
      slot_rem_r[sel] <= rem_new;
      slot_vr_r[sel]  <= vr_new;
    end
  end

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_kind       <= kind_nxt;
      out_ran_slot   <= slot_nxt;
      out_length     <= len_nxt;
      out_end_time   <= now_nxt;
      out_finished   <= fin_nxt;
      out_turnaround <= turn_nxt;
      out_waiting    <= wait_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  a_slice_bound: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && do_run |-> (run != '0) && (run <= bs))
    else $error("slice outside slice limit");

  a_wait_le_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == wfd_pkg::KIND_RAN && out_finished |-> out_waiting <= out_turnaround)
    else $error("waiting exceeds turnaround");

  a_idle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && kind_nxt == wfd_pkg::KIND_IDLE |-> len_nxt != '0)
    else $error("idle gap of zero length");

  a_clear_time: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && do_clear |=> now_r == '0 && slot_valid_r == '0)
    else $error("clear left state behind");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid && out_stall)
    else $error("input stalled with room to advance");

endmodule

@@ design/wfd_cfg.sv @@
// Configuration register block (APB-style write/read) of the dispatcher.
// Depends on wfd_pkg for the slice limit width and reset value.
module wfd_cfg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output logic [wfd_pkg::BS_W-1:0] slice_limit
);

  logic [wfd_pkg::BS_W-1:0] slice_limit_r;
  logic                     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_limit_r <= wfd_pkg::SLICE_LIMIT_RST;
    end else if (wr_en) begin
      slice_limit_r <= pwdata[wfd_pkg::BS_W-1:0];
    end
  end

  assign prdata      = (paddr[2] == 1'b0) ? {{(32 - wfd_pkg::BS_W){1'b0}}, slice_limit_r}
                                          : 32'd0;
  assign slice_limit = slice_limit_r;

endmodule

@@ design/wfd_pick.sv @@
// Comparison tree that picks the ready task with least virtual runtime
// and the earliest pending arrival. Depends on wfd_pkg.
module wfd_pick #(
  parameter int SLOTS = 8
) (
  input  logic [SLOTS-1:0]                      elig,
  input  logic [SLOTS-1:0][wfd_pkg::VR_W-1:0]   vr,
  input  logic [SLOTS-1:0][wfd_pkg::ARR_W-1:0]  arr,
  input  logic [wfd_pkg::NOW_W-1:0]             now,
  output wfd_pkg::pick_t                        pick
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NL = 1 << IW;

  logic [2*NL-1:0]                     c_ok;
  logic [2*NL-1:0][wfd_pkg::VR_W-1:0]  c_vr;
  logic [2*NL-1:0][wfd_pkg::ARR_W-1:0] c_arr;
  logic [2*NL-1:0][IW-1:0]             c_idx;
  logic [2*NL-1:0]                     p_ok;
  logic [2*NL-1:0][wfd_pkg::ARR_W-1:0] p_arr;

  always_comb begin
    logic take_r;
    c_ok  = '0;
    c_vr  = '0;
    c_arr = '0;
    c_idx = '0;
    p_ok  = '0;
    p_arr = '0;
    // leaves: ready tasks compete on runtime, future ones on arrival
    for (int i = 0; i < SLOTS; i++) begin
      c_vr[NL+i]  = vr[i];
      c_arr[NL+i] = arr[i];
      c_idx[NL+i] = IW'(i);
      p_arr[NL+i] = arr[i];
      c_ok[NL+i]  = elig[i] && ({{(wfd_pkg::NOW_W - wfd_pkg::ARR_W){1'b0}}, arr[i]} <= now);
      p_ok[NL+i]  = elig[i] && !c_ok[NL+i];
    end
    // left child holds lower slots, so it wins a full tie
    for (int n = NL - 1; n >= 1; n--) begin
      take_r = c_ok[2*n+1] && (!c_ok[2*n] ||
               (c_vr[2*n+1] < c_vr[2*n]) ||
               ((c_vr[2*n+1] == c_vr[2*n]) && (c_arr[2*n+1] < c_arr[2*n])));
      c_ok[n]  = c_ok[2*n] || c_ok[2*n+1];
      c_vr[n]  = take_r ? c_vr[2*n+1]  : c_vr[2*n];
      c_arr[n] = take_r ? c_arr[2*n+1] : c_arr[2*n];
      c_idx[n] = take_r ? c_idx[2*n+1] : c_idx[2*n];
      p_ok[n]  = p_ok[2*n] || p_ok[2*n+1];
      p_arr[n] = (p_ok[2*n+1] && (!p_ok[2*n] || (p_arr[2*n+1] < p_arr[2*n])))
                 ? p_arr[2*n+1] : p_arr[2*n];
    end
  end

  assign pick.found    = c_ok[1];
  assign pick.idx      = wfd_pkg::MAX_IDX_W'(c_idx[1]);
  assign pick.pending  = p_ok[1];
  assign pick.next_arr = p_arr[1];

endmodule
